// ===== src/arpm_pkg.sv =====
// shared types, constants and helpers for the rms and peak meter
package arpm_pkg;

  // default geometry of the sample ring
  localparam int RING_FRAMES_DEF  = 8192;
  localparam int MAX_CHANNELS_DEF = 2;

  // field and register widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;
  localparam int CC_W      = 2;
  localparam int SUM_W     = 48;

  // largest reportable rms level
  localparam logic [LEVEL_W-1:0] RMS_CAP = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW   = 2'd2;

  // input item
  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] window_peak;
    logic [LEVEL_W-1:0] overall_peak;
  } out_item_t;

  // absolute value of a raw sample, minimum sample gives 32768
  function automatic logic [LEVEL_W-1:0] magnitude(input logic [SAMPLE_W-1:0] raw);
    magnitude = raw[SAMPLE_W-1] ? (~raw + 16'd1) : raw;
  endfunction

endpackage

// ===== src/arpm_ram.sv =====
// generic simple dual port ram with registered read
module arpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/audio_rms_peak_meter_core.sv =====
// moving window rms and peak meter, top level with its sequencer
// sample item: busy after acceptance, no new item until done (ring read, squares, write)
// tick item: the ring walk reads one slot per cycle through the single ram read port,
//   then 16 root steps (square, scale, compare) share one multiplier
// result comes out of an output register; samples are taken while a result waits
// after reset a clearing pass zeroes all RING_FRAMES * MAX_CHANNELS ring slots with in_stall high
module audio_rms_peak_meter_core #(
  parameter int RING_FRAMES  = arpm_pkg::RING_FRAMES_DEF,
  parameter int MAX_CHANNELS = arpm_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  arpm_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output arpm_pkg::out_item_t                out_item,
  input  logic                               cfg_we,
  input  logic [arpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arpm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DEPTH = RING_FRAMES * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FR_W  = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW    = ((FR_W > arpm_pkg::CFG_W) ? FR_W : arpm_pkg::CFG_W) + 1;
  localparam int DIV_W = 17;
  localparam int MA_W  = 32;
  localparam int MP_W  = MA_W + DIV_W;

  localparam logic [AW-1:0]   LAST_SLOT  = AW'(DEPTH - 1);
  localparam logic [AW-1:0]   MC_A       = AW'(MAX_CHANNELS);
  localparam logic [FR_W-1:0] LAST_FRAME = FR_W'(RING_FRAMES - 1);

  // sequencer states
  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_READ   = 10'b0000000100,
    S_ADDNEW = 10'b0000001000,
    S_SUBOLD = 10'b0000010000,
    S_PEAK   = 10'b0000100000,
    S_RSQ    = 10'b0001000000,
    S_RMUL   = 10'b0010000000,
    S_RCMP   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [arpm_pkg::CC_W-1:0]  channel_count;
  logic [arpm_pkg::CFG_W-1:0] rms_window;
  logic [arpm_pkg::CFG_W-1:0] peak_window;

  // meter state
  logic [FR_W-1:0]            write_position;
  logic [CH_W-1:0]            channel_position;
  logic [arpm_pkg::SUM_W-1:0] square_sum;
  logic [15:0]                all_time_peak;

  // working registers
  logic [AW-1:0]   clr_addr;
  logic [15:0]     sample_reg;
  logic [MP_W-1:0] prod;
  logic [DIV_W-1:0] div;
  logic [FR_W-1:0] peak_frame;
  logic [CH_W-1:0] peak_ch;
  logic [arpm_pkg::CFG_W-1:0] peak_cnt;
  logic            issue_on;
  logic            rd_pend;
  logic [15:0]     peak;
  logic [15:0]     root;
  logic [15:0]     root_bit;

  // ram ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  // effective configuration
  logic [arpm_pkg::CC_W-1:0]  eff_ch;
  logic [arpm_pkg::CFG_W-1:0] eff_rw;
  logic [arpm_pkg::CFG_W-1:0] eff_pw;

  always_comb begin
    if (channel_count == '0) begin
      eff_ch = arpm_pkg::CC_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      eff_ch = arpm_pkg::CC_W'(MAX_CHANNELS);
    end else begin
      eff_ch = channel_count;
    end
    if (rms_window == '0) begin
      eff_rw = arpm_pkg::CFG_W'(1);
    end else if (32'(rms_window) > RING_FRAMES) begin
      eff_rw = arpm_pkg::CFG_W'(RING_FRAMES);
    end else begin
      eff_rw = rms_window;
    end
    if (peak_window == '0) begin
      eff_pw = arpm_pkg::CFG_W'(1);
    end else if (32'(peak_window) > RING_FRAMES) begin
      eff_pw = arpm_pkg::CFG_W'(RING_FRAMES);
    end else begin
      eff_pw = peak_window;
    end
  end

  // frame leaving the rms window
  logic [CW-1:0]   wp_ext;
  logic [CW-1:0]   rw_ext;
  logic [CW-1:0]   old_diff;
  logic [FR_W-1:0] old_frame;

  always_comb begin
    wp_ext   = CW'(write_position);
    rw_ext   = CW'(eff_rw);
    old_diff = wp_ext - rw_ext;
    if (wp_ext < rw_ext) begin
      old_diff = old_diff + CW'(RING_FRAMES);
    end
    old_frame = old_diff[FR_W-1:0];
  end

  // slot addresses
  logic [AW-1:0] old_addr;
  logic [AW-1:0] new_addr;
  logic [AW-1:0] peak_addr;

  assign old_addr  = AW'(old_frame) * MC_A + AW'(channel_position);
  assign new_addr  = AW'(write_position) * MC_A + AW'(channel_position);
  assign peak_addr = AW'(peak_frame) * MC_A + AW'(peak_ch);

  // root trial value and its odd term 2c-1
  logic [15:0] cand;
  logic [16:0] odd;

  assign cand = root | root_bit;
  assign odd  = {cand, 1'b0} - 17'd1;

  // shared multiplier
  logic [15:0]     mag_new;
  logic [15:0]     mag_old;
  logic [MA_W-1:0] mul_a;
  logic [DIV_W-1:0] mul_b;
  logic [MP_W-1:0] mul_p;

  assign mag_new = arpm_pkg::magnitude(sample_reg);
  assign mag_old = arpm_pkg::magnitude(ram_rdata);

  always_comb begin
    unique case (state)
      S_READ: begin
        mul_a = MA_W'(mag_new);
        mul_b = DIV_W'(mag_new);
      end
      S_ADDNEW: begin
        mul_a = MA_W'(mag_old);
        mul_b = DIV_W'(mag_old);
      end
      S_RSQ: begin
        mul_a = MA_W'(odd);
        mul_b = odd;
      end
      S_RMUL: begin
        mul_a = prod[MA_W-1:0];
        mul_b = div;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  // ram access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = new_addr;
    ram_wdata = sample_reg;
    ram_raddr = old_addr;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_ADDNEW: begin
        ram_we = 1'b1;
      end
      S_PEAK: begin
        ram_raddr = peak_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  arpm_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshakes
  logic in_acc;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= arpm_pkg::CC_W'(2);
      rms_window    <= arpm_pkg::CFG_W'(4410);
      peak_window   <= arpm_pkg::CFG_W'(8192);
    end else if (cfg_we) begin
      unique case (cfg_index)
        arpm_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[arpm_pkg::CC_W-1:0];
        arpm_pkg::REG_RMS_WINDOW:    rms_window    <= cfg_data;
        arpm_pkg::REG_PEAK_WINDOW:   peak_window   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // comparison terms for the root step and the ring walk
  logic [MP_W:0] four_s;
  logic          last_ch;

  assign four_s  = {square_sum, 2'b00};
  assign last_ch = (32'(peak_ch) + 1) >= 32'(eff_ch);

  // output register valid flag, loaded from the done state, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      write_position   <= '0;
      channel_position <= '0;
      square_sum       <= '0;
      all_time_peak    <= '0;
      issue_on         <= 1'b0;
      rd_pend          <= 1'b0;
    end else begin
      unique case (state)
        // ring cleared one slot a cycle
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            sample_reg <= in_item.sample;
            if (in_item.func) begin
              // set up the ring walk and the divisor
              peak_frame <= (write_position == '0) ? LAST_FRAME
                                                   : write_position - FR_W'(1);
              peak_ch    <= '0;
              peak_cnt   <= eff_pw;
              issue_on   <= 1'b1;
              rd_pend    <= 1'b0;
              peak       <= '0;
              root       <= '0;
              root_bit   <= 16'h8000;
              unique case (eff_ch)
                2'd2:    div <= {2'b00, eff_rw, 1'b0};
                2'd3:    div <= {3'b000, eff_rw} + {2'b00, eff_rw, 1'b0};
                default: div <= {3'b000, eff_rw};
              endcase
              state <= S_PEAK;
            end else begin
              state <= S_READ;
            end
          end
        end
        // old slot read issued, new square formed
        S_READ: begin
          prod  <= mul_p;
          state <= S_ADDNEW;
        end
        // add new square, square the leaving sample, write the ring
        S_ADDNEW: begin
          square_sum <= square_sum + prod[arpm_pkg::SUM_W-1:0];
          prod       <= mul_p;
          state      <= S_SUBOLD;
        end
        // subtract leaving square, update the overall peak, advance position
        S_SUBOLD: begin
          square_sum <= square_sum - prod[arpm_pkg::SUM_W-1:0];
          if (mag_new > all_time_peak) begin
            all_time_peak <= mag_new;
          end
          if ((32'(channel_position) + 1) >= 32'(eff_ch)) begin
            channel_position <= '0;
            write_position   <= (write_position == LAST_FRAME) ? '0
                                : write_position + FR_W'(1);
          end else begin
            channel_position <= channel_position + CH_W'(1);
          end
          state <= S_IDLE;
        end
        // walk the newest frames, one slot read per cycle
        S_PEAK: begin
          rd_pend <= issue_on;
          if (rd_pend && (mag_old > peak)) begin
            peak <= mag_old;
          end
          if (issue_on) begin
            if (last_ch) begin
              peak_ch    <= '0;
              peak_cnt   <= peak_cnt - arpm_pkg::CFG_W'(1);
              peak_frame <= (peak_frame == '0) ? LAST_FRAME : peak_frame - FR_W'(1);
              if (peak_cnt == arpm_pkg::CFG_W'(1)) begin
                issue_on <= 1'b0;
              end
            end else begin
              peak_ch <= peak_ch + CH_W'(1);
            end
          end else if (!rd_pend) begin
            state <= S_RSQ;
          end
        end
        // root step: square the odd term
        S_RSQ: begin
          prod  <= mul_p;
          state <= S_RMUL;
        end
        // root step: scale by the divisor
        S_RMUL: begin
          prod  <= mul_p;
          state <= S_RCMP;
        end
        // root step: keep the bit if the trial fits
        S_RCMP: begin
          if ((cand <= arpm_pkg::RMS_CAP) && ({1'b0, prod} <= four_s)) begin
            root <= cand;
          end
          root_bit <= root_bit >> 1;
          state    <= root_bit[0] ? S_DONE : S_RSQ;
        end
        // hand the result to the output register
        S_DONE: begin
          if (out_free) begin
            out_item.rms_level    <= root;
            out_item.window_peak  <= peak;
            out_item.overall_peak <= all_time_peak;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/arpm_checker.sv =====
// port level checks for the rms and peak meter, bound to the top level
module arpm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input arpm_pkg::in_item_t             in_item,
  input logic                           out_valid,
  input logic                           out_stall,
  input arpm_pkg::out_item_t            out_item,
  input logic                           cfg_we,
  input logic [arpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [arpm_pkg::CFG_W-1:0]     cfg_data
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken straight after reset");

  // every taken item raises in_stall right after it
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after taking an item");

  // a held result does not change
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed or dropped");

  // result levels stay in range and the window peak never beats the overall one
  a_levels_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.rms_level <= arpm_pkg::RMS_CAP) &&
                   (out_item.overall_peak <= arpm_pkg::RMS_CAP) &&
                   (out_item.window_peak <= out_item.overall_peak)))
    else $error("result levels out of range");

endmodule

bind audio_rms_peak_meter_core arpm_checker u_arpm_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking testbench for the rms and peak meter: scoreboard class, drivers and monitors
module tb_top;

  localparam int RING  = arpm_pkg::RING_FRAMES_DEF;
  localparam int CHANS = arpm_pkg::MAX_CHANNELS_DEF;

  // input item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // settings the block comes out of reset with
  localparam logic [arpm_pkg::CC_W-1:0]  CC_AT_RESET   = 2'd2;
  localparam logic [arpm_pkg::CFG_W-1:0] RMS_AT_RESET  = 14'd4410;
  localparam logic [arpm_pkg::CFG_W-1:0] PEAK_AT_RESET = 14'd8192;

  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 200000;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 120;
  localparam int WRAP_ITEMS    = 120;

  // predicts meter readings from accepted items and checks what comes out
  class meter_scoreboard;
    logic [arpm_pkg::SAMPLE_W-1:0] ring [RING*CHANS];
    int unsigned                   frame_pos;
    int unsigned                   slot_pos;
    logic [arpm_pkg::SUM_W-1:0]    energy;
    logic [arpm_pkg::LEVEL_W-1:0]  top_peak;
    logic [arpm_pkg::CC_W-1:0]     chan_reg;
    logic [arpm_pkg::CFG_W-1:0]    rms_reg;
    logic [arpm_pkg::CFG_W-1:0]    peak_reg;
    arpm_pkg::out_item_t           readings [$];
    int unsigned                   samples;
    int unsigned                   ticks;
    int unsigned                   checked;
    int unsigned                   failures;

    function new();
      foreach (ring[i]) ring[i] = '0;
      frame_pos = 0;
      slot_pos  = 0;
      energy    = '0;
      top_peak  = '0;
      chan_reg  = CC_AT_RESET;
      rms_reg   = RMS_AT_RESET;
      peak_reg  = PEAK_AT_RESET;
      samples   = 0;
      ticks     = 0;
      checked   = 0;
      failures  = 0;
    endfunction

    // absolute value, the most negative sample gives 32768
    function logic [arpm_pkg::LEVEL_W-1:0] level_of(logic [arpm_pkg::SAMPLE_W-1:0] raw);
      return raw[arpm_pkg::SAMPLE_W-1] ? arpm_pkg::LEVEL_W'(17'h10000 - raw) : raw;
    endfunction

    // zero acts as one, anything past the ring acts as the whole ring
    function int unsigned frames_of(logic [arpm_pkg::CFG_W-1:0] w);
      if (w == 0) return 1;
      if (w > RING) return RING;
      return w;
    endfunction

    function int unsigned channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > CHANS) return CHANS;
      return chan_reg;
    endfunction

    // largest r up to the cap with div * (2r - 1)^2 <= 4 * sum
    function logic [arpm_pkg::LEVEL_W-1:0] root_level(logic [arpm_pkg::SUM_W-1:0] sum,
                                                      int unsigned div);
      longint unsigned quad;
      longint unsigned cand;
      longint unsigned odd;
      logic [arpm_pkg::LEVEL_W-1:0] r;
      int b;
      quad = 64'(sum) << 2;
      r = '0;
      for (b = arpm_pkg::LEVEL_W - 1; b >= 0; b--) begin
        cand = 64'(r) | (64'd1 << b);
        odd  = 2 * cand - 1;
        if (cand <= arpm_pkg::RMS_CAP && 64'(div) * odd * odd <= quad)
          r = arpm_pkg::LEVEL_W'(cand);
      end
      return r;
    endfunction

    function void set_reg(logic [arpm_pkg::CFG_IDX_W-1:0] idx,
                          logic [arpm_pkg::CFG_W-1:0] data);
      case (idx)
        arpm_pkg::REG_CHANNEL_COUNT: chan_reg = data[arpm_pkg::CC_W-1:0];
        arpm_pkg::REG_RMS_WINDOW:    rms_reg  = data;
        arpm_pkg::REG_PEAK_WINDOW:   peak_reg = data;
        default: ;
      endcase
    endfunction

    function void note_item(arpm_pkg::in_item_t it);
      int unsigned chs;
      int unsigned cp;
      int unsigned old_frame;
      int unsigned frame;
      int unsigned j;
      logic [arpm_pkg::LEVEL_W-1:0] lvl;
      logic [arpm_pkg::LEVEL_W-1:0] gone;
      logic [arpm_pkg::LEVEL_W-1:0] peak;
      arpm_pkg::out_item_t want;
      chs = channels();
      if (it.func == FUNC_SAMPLE) begin
        samples++;
        // same-channel slot leaving the window, read ahead of this write
        cp = slot_pos % CHANS;
        old_frame = (frame_pos + RING - frames_of(rms_reg)) % RING;
        gone = level_of(ring[old_frame*CHANS + cp]);
        lvl  = level_of(it.sample);
        if (lvl > top_peak) top_peak = lvl;
        energy = energy + arpm_pkg::SUM_W'(lvl) * arpm_pkg::SUM_W'(lvl)
                 - arpm_pkg::SUM_W'(gone) * arpm_pkg::SUM_W'(gone);
        ring[frame_pos*CHANS + cp] = it.sample;
        cp++;
        if (cp >= chs) begin
          cp = 0;
          frame_pos = (frame_pos + 1) % RING;
        end
        slot_pos = cp;
      end else begin
        ticks++;
        // walk back from the newest complete frame
        peak  = '0;
        frame = frame_pos;
        repeat (frames_of(peak_reg)) begin
          frame = (frame + RING - 1) % RING;
          for (j = 0; j < chs; j++) begin
            lvl = level_of(ring[frame*CHANS + j]);
            if (lvl > peak) peak = lvl;
          end
        end
        want.rms_level    = root_level(energy, frames_of(rms_reg) * chs);
        want.window_peak  = peak;
        want.overall_peak = top_peak;
        readings.push_back(want);
      end
    endfunction

    function void check_result(arpm_pkg::out_item_t got);
      arpm_pkg::out_item_t want;
      checked++;
      if (readings.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("reading with none expected: rms %0d window %0d overall %0d",
                   got.rms_level, got.window_peak, got.overall_peak);
        return;
      end
      want = readings.pop_front();
      if (got.rms_level !== want.rms_level || got.window_peak !== want.window_peak ||
          got.overall_peak !== want.overall_peak) begin
        failures++;
        if (failures <= 10)
          $display("reading %0d: rms %0d/%0d window %0d/%0d overall %0d/%0d (exp/got)",
                   checked, want.rms_level, got.rms_level, want.window_peak,
                   got.window_peak, want.overall_peak, got.overall_peak);
      end
    endfunction

    function int unsigned outstanding();
      return readings.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  arpm_pkg::in_item_t             in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  arpm_pkg::out_item_t            out_item;
  logic                           cfg_we    = 1'b0;
  logic [arpm_pkg::CFG_IDX_W-1:0] cfg_index = arpm_pkg::REG_CHANNEL_COUNT;
  logic [arpm_pkg::CFG_W-1:0]     cfg_data  = '0;

  meter_scoreboard sb;
  int unsigned     burst_left = 0;
  int unsigned     stall_pct  = 0;
  int unsigned     stall_left = 0;
  int unsigned     settings_written = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  audio_rms_peak_meter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // receiver stall rate is redrawn whenever a random hold count runs out, zero included
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 50;
        default: stall_pct <= 88;
      endcase
      stall_left <= $urandom_range(8, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_item);
  end

  // ends the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d cycles with no item moving", quiet);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic arpm_pkg::in_item_t make_item(logic func,
                                                   logic signed [arpm_pkg::SAMPLE_W-1:0] value);
    arpm_pkg::in_item_t it;
    it.func   = func;
    it.sample = value;
    return it;
  endfunction

  function automatic logic [arpm_pkg::CFG_W-1:0] pick_window(int unsigned sel);
    case (sel)
      0: return arpm_pkg::CFG_W'($urandom_range(0, 3));
      1: return arpm_pkg::CFG_W'($urandom_range(4, 64));
      2: return arpm_pkg::CFG_W'($urandom_range(65, 8191));
      3: return arpm_pkg::CFG_W'(RING);
      4: return arpm_pkg::CFG_W'($urandom_range(RING + 1, 16383));
      default: return '1;
    endcase
  endfunction

  task automatic rest(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender works in bursts, a few of them long enough to run with no gap at all
  task automatic send_item(input arpm_pkg::in_item_t it);
    if (burst_left == 0) begin
      rest(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6));
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(it);
  endtask

  // wait for every reading, then let a last sample finish inside the block
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // upper data bits of the channel count are junk the block must drop
  task automatic program_regs(input logic [arpm_pkg::CC_W-1:0] cc,
                              input logic [arpm_pkg::CFG_W-1:0] rw,
                              input logic [arpm_pkg::CFG_W-1:0] pw);
    logic [arpm_pkg::CFG_W-1:0] cc_data;
    cc_data   = arpm_pkg::CFG_W'({$urandom, cc});
    cfg_we    <= 1'b1;
    cfg_index <= arpm_pkg::REG_CHANNEL_COUNT;
    cfg_data  <= cc_data;
    @(posedge clk);
    sb.set_reg(arpm_pkg::REG_CHANNEL_COUNT, cc_data);
    cfg_index <= arpm_pkg::REG_RMS_WINDOW;
    cfg_data  <= rw;
    @(posedge clk);
    sb.set_reg(arpm_pkg::REG_RMS_WINDOW, rw);
    cfg_index <= arpm_pkg::REG_PEAK_WINDOW;
    cfg_data  <= pw;
    @(posedge clk);
    sb.set_reg(arpm_pkg::REG_PEAK_WINDOW, pw);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // samples lean towards the extremes and small values, ticks carry junk samples
  task automatic send_random(input int unsigned count, input int unsigned tick_odds);
    arpm_pkg::in_item_t it;
    int unsigned i;
    for (i = 0; i < count; i++) begin
      it.func = ($urandom_range(1, tick_odds) == 1) ? FUNC_TICK : FUNC_SAMPLE;
      case ($urandom_range(0, 9))
        0: it.sample = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        1: it.sample = $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
        2, 3: it.sample = arpm_pkg::SAMPLE_W'($urandom_range(0, 127)) - 16'sd64;
        default: it.sample = arpm_pkg::SAMPLE_W'($urandom);
      endcase
      send_item(it);
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    logic [arpm_pkg::CFG_W-1:0] rw;
    logic [arpm_pkg::CFG_W-1:0] pw;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: cleared ring, then one frame at both extremes
    send_item(make_item(FUNC_TICK, 16'sh0000));
    send_item(make_item(FUNC_SAMPLE, 16'sh8000));
    send_item(make_item(FUNC_SAMPLE, 16'sh7fff));
    send_item(make_item(FUNC_TICK, 16'sh0000));

    // stereo, short windows, a partial frame left out of the window peak
    settle();
    program_regs(2'd2, 14'd2, 14'd1);
    send_item(make_item(FUNC_SAMPLE, 16'sh0000));
    send_item(make_item(FUNC_SAMPLE, 16'shffff));
    send_item(make_item(FUNC_TICK, 16'sh0000));
    send_item(make_item(FUNC_SAMPLE, 16'sh0001));
    send_item(make_item(FUNC_TICK, 16'sh0000));
    send_item(make_item(FUNC_SAMPLE, 16'sh7fff));
    send_item(make_item(FUNC_TICK, 16'sh0000));

    // switch to mono, sum left inconsistent so the level can saturate
    settle();
    program_regs(2'd1, 14'd1, 14'd2);
    send_item(make_item(FUNC_SAMPLE, 16'sh8000));
    send_item(make_item(FUNC_TICK, 16'sh0000));
    send_item(make_item(FUNC_SAMPLE, 16'sh0005));
    send_item(make_item(FUNC_TICK, 16'sh0000));

    // zero settings act as one
    settle();
    program_regs(2'd0, 14'd0, 14'd0);
    send_item(make_item(FUNC_SAMPLE, 16'sh8001));
    send_item(make_item(FUNC_TICK, 16'sh0000));
    send_item(make_item(FUNC_TICK, 16'sh8000));

    // over-range settings clamp, rms window as long as the ring
    settle();
    program_regs(2'd3, 14'h3fff, 14'h3fff);
    send_item(make_item(FUNC_SAMPLE, 16'sh7fff));
    send_item(make_item(FUNC_SAMPLE, 16'sh8000));
    send_item(make_item(FUNC_TICK, 16'sh0000));

    // random phases, long peak windows only now and then since each tick walks them
    for (p = 0; p < NUM_PHASES; p++) begin
      rw = pick_window(p % 6);
      pw = (p % 4 == 3) ? pick_window(3 + p % 3)
                        : arpm_pkg::CFG_W'($urandom_range(0, 48));
      settle();
      program_regs(arpm_pkg::CC_W'(p % 4), rw, pw);
      send_random(PHASE_ITEMS, (p % 4 == 3) ? 50 : 8);
    end

    // mono with an rms window as long as the ring
    settle();
    program_regs(2'd1, arpm_pkg::CFG_W'(RING), arpm_pkg::CFG_W'($urandom_range(1, 16)));
    send_random(WRAP_ITEMS, 64);

    settle();
    $display("covered %0d samples and %0d ticks over %0d register settings",
             sb.samples, sb.ticks, settings_written);
    $display("%0d readings checked, %0d failing, %0d never arrived",
             sb.checked, sb.failures, sb.outstanding());
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
